// ===== sv/pt2d_pkg.sv =====
package pt2d_pkg;

    // default sizes
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // fixed field widths
    localparam int TRIG_FRAC    = 14;
    localparam int FACTOR_BITS  = 16;
    localparam int ANGLE_BITS   = 9;
    localparam int CMD_BITS     = 3;
    localparam int REG_IDX_BITS = 3;

    // factor reset value, 1.0 in Q8.8
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = 16'd256;
    // cosine of zero degrees in Q1.14
    localparam logic signed [FACTOR_BITS-1:0] TRIG_ONE = 16'sd16384;

    // configuration register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_SHIFT_X = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SHIFT_Y = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SCALE_X = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SCALE_Y = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SHEAR   = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_ANGLE   = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_PIVOT_X = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_PIVOT_Y = 3'd7;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_TRANSLATE = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ROTATE    = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_SCALE     = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_REFLECT_Y = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_REFLECT_X = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_REFLECT_XY = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_SHEAR_X   = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_SHEAR_Y   = 3'd7;

    // control that travels with a transaction down the pipe
    typedef struct packed {
        logic valid;
        logic rot;
    } stage_ctrl_t;

    // sin of 0..90 degrees in Q1.14
    function automatic logic [14:0] quarter_sine(input logic [6:0] r);
        logic [14:0] v;
        begin
            case (r)
                7'd0: v = 15'd0;      7'd1: v = 15'd286;    7'd2: v = 15'd572;
                7'd3: v = 15'd857;    7'd4: v = 15'd1143;   7'd5: v = 15'd1428;
                7'd6: v = 15'd1713;   7'd7: v = 15'd1997;   7'd8: v = 15'd2280;
                7'd9: v = 15'd2563;   7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
                7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
                7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
                7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
                7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
                7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
                7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
                7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
                7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
                7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
                7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
                7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
                7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
                7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
                7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
                7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
                7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
                7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
                7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
                7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
                7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
                7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
                7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
                7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
                7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
                7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
                7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
                7'd90: v = 15'd16384;
                default: v = 15'd0;
            endcase
            return v;
        end
    endfunction

    // signed sine in Q1.14 of an angle already reduced to 0..359
    function automatic logic signed [FACTOR_BITS-1:0] sine_deg(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS-1:0] r;
        logic                  neg;
        logic [14:0]           mag;
        begin
            neg = 1'b0;
            if (a < 9'd90) begin
                r = a;
            end else if (a < 9'd180) begin
                r = 9'd180 - a;
            end else if (a < 9'd270) begin
                r = a - 9'd180;
                neg = 1'b1;
            end else begin
                r = 9'd360 - a;
                neg = 1'b1;
            end
            mag = quarter_sine(r[6:0]);
            return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    endfunction

endpackage

// ===== sv/pt2d_cfg.sv =====
module pt2d_cfg
    import pt2d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int CFG_W      = FACTOR_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [REG_IDX_BITS-1:0]        cfg_index,
    input  logic [CFG_W-1:0]               cfg_wdata,
    output logic signed [COORD_BITS-1:0]   shift_x,
    output logic signed [COORD_BITS-1:0]   shift_y,
    output logic signed [FACTOR_BITS-1:0]  scale_x,
    output logic signed [FACTOR_BITS-1:0]  scale_y,
    output logic signed [FACTOR_BITS-1:0]  shear_factor,
    output logic signed [FACTOR_BITS-1:0]  sin_val,
    output logic signed [FACTOR_BITS-1:0]  cos_val,
    output logic signed [FACTOR_BITS-1:0]  nsin_val,
    output logic signed [COORD_BITS-1:0]   pivot_x,
    output logic signed [COORD_BITS-1:0]   pivot_y
);

    logic signed [COORD_BITS-1:0]  shift_x_reg, shift_y_reg, pivot_x_reg, pivot_y_reg;
    logic signed [FACTOR_BITS-1:0] scale_x_reg, scale_y_reg, shear_reg;
    logic signed [FACTOR_BITS-1:0] sin_reg, cos_reg, nsin_reg;
    logic signed [FACTOR_BITS-1:0] sin_next, cos_next;
    logic [ANGLE_BITS-1:0]         ang_raw, ang_mod, ang_cos;
    logic [ANGLE_BITS:0]           ang_plus;

    // reduce the written angle and look up sine and cosine once per write
    always_comb
    begin
        ang_raw  = cfg_wdata[ANGLE_BITS-1:0];
        ang_mod  = (ang_raw >= 9'd360) ? ang_raw - 9'd360 : ang_raw;
        ang_plus = {1'b0, ang_mod} + 10'd90;
        ang_cos  = (ang_plus >= 10'd360) ? 9'(ang_plus - 10'd360) : ang_plus[ANGLE_BITS-1:0];
        sin_next = sine_deg(ang_mod);
        cos_next = sine_deg(ang_cos);
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            scale_x_reg <= FACTOR_ONE;
            scale_y_reg <= FACTOR_ONE;
            shear_reg   <= '0;
            sin_reg     <= '0;
            cos_reg     <= TRIG_ONE;
            nsin_reg    <= '0;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SHIFT_X: shift_x_reg <= cfg_wdata[COORD_BITS-1:0];
                REG_SHIFT_Y: shift_y_reg <= cfg_wdata[COORD_BITS-1:0];
                REG_SCALE_X: scale_x_reg <= cfg_wdata[FACTOR_BITS-1:0];
                REG_SCALE_Y: scale_y_reg <= cfg_wdata[FACTOR_BITS-1:0];
                REG_SHEAR:   shear_reg   <= cfg_wdata[FACTOR_BITS-1:0];
                REG_ANGLE:
                begin
                    sin_reg  <= sin_next;
                    cos_reg  <= cos_next;
                    nsin_reg <= -sin_next;
                end
                REG_PIVOT_X: pivot_x_reg <= cfg_wdata[COORD_BITS-1:0];
                REG_PIVOT_Y: pivot_y_reg <= cfg_wdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign shift_x      = shift_x_reg;
    assign shift_y      = shift_y_reg;
    assign scale_x      = scale_x_reg;
    assign scale_y      = scale_y_reg;
    assign shear_factor = shear_reg;
    assign sin_val      = sin_reg;
    assign cos_val      = cos_reg;
    assign nsin_val     = nsin_reg;
    assign pivot_x      = pivot_x_reg;
    assign pivot_y      = pivot_y_reg;

endmodule

// ===== sv/pt2d_prep.sv =====
module pt2d_prep
    import pt2d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [CMD_BITS-1:0]             command,
    input  logic signed [COORD_BITS-1:0]    point_x,
    input  logic signed [COORD_BITS-1:0]    point_y,
    input  logic signed [COORD_BITS-1:0]    shift_x,
    input  logic signed [COORD_BITS-1:0]    shift_y,
    input  logic signed [FACTOR_BITS-1:0]   scale_x,
    input  logic signed [FACTOR_BITS-1:0]   scale_y,
    input  logic signed [FACTOR_BITS-1:0]   shear_factor,
    input  logic signed [FACTOR_BITS-1:0]   sin_val,
    input  logic signed [FACTOR_BITS-1:0]   cos_val,
    input  logic signed [FACTOR_BITS-1:0]   nsin_val,
    input  logic signed [COORD_BITS-1:0]    pivot_x,
    input  logic signed [COORD_BITS-1:0]    pivot_y,
    output stage_ctrl_t                     ctrl,
    output logic signed [COORD_BITS+1:0]    base_x,
    output logic signed [COORD_BITS+1:0]    base_y,
    output logic signed [COORD_BITS:0]      ax1,
    output logic signed [COORD_BITS:0]      ax2,
    output logic signed [COORD_BITS:0]      ay1,
    output logic signed [COORD_BITS:0]      ay2,
    output logic signed [FACTOR_BITS-1:0]   bx1,
    output logic signed [FACTOR_BITS-1:0]   bx2,
    output logic signed [FACTOR_BITS-1:0]   by1,
    output logic signed [FACTOR_BITS-1:0]   by2
);

    localparam int OP_W   = COORD_BITS + 1;
    localparam int BASE_W = COORD_BITS + 2;

    stage_ctrl_t                  ctrl_reg;
    logic signed [BASE_W-1:0]     base_x_reg, base_y_reg, base_x_next, base_y_next;
    logic signed [OP_W-1:0]       ax1_reg, ax2_reg, ay1_reg, ay2_reg;
    logic signed [OP_W-1:0]       ax1_next, ax2_next, ay1_next, ay2_next;
    logic signed [FACTOR_BITS-1:0] bx1_reg, bx2_reg, by1_reg, by2_reg;
    logic signed [FACTOR_BITS-1:0] bx1_next, bx2_next, by1_next, by2_next;
    logic signed [OP_W-1:0]       dx, dy;
    logic                         rot_next;

    // command decode: integer base term and multiplier operands per axis
    always_comb
    begin
        dx          = OP_W'(point_x) - OP_W'(pivot_x);
        dy          = OP_W'(point_y) - OP_W'(pivot_y);
        base_x_next = BASE_W'(point_x);
        base_y_next = BASE_W'(point_y);
        ax1_next    = '0;
        ax2_next    = '0;
        ay1_next    = '0;
        ay2_next    = '0;
        bx1_next    = '0;
        bx2_next    = '0;
        by1_next    = '0;
        by2_next    = '0;
        rot_next    = 1'b0;
        unique case (command)
            CMD_TRANSLATE:
            begin
                base_x_next = BASE_W'(point_x) + BASE_W'(shift_x);
                base_y_next = BASE_W'(point_y) + BASE_W'(shift_y);
            end
            CMD_ROTATE:
            begin
                rot_next    = 1'b1;
                base_x_next = BASE_W'(pivot_x);
                base_y_next = BASE_W'(pivot_y);
                ax1_next    = dx;
                bx1_next    = cos_val;
                ax2_next    = dy;
                bx2_next    = nsin_val;
                ay1_next    = dx;
                by1_next    = sin_val;
                ay2_next    = dy;
                by2_next    = cos_val;
            end
            CMD_SCALE:
            begin
                base_x_next = '0;
                base_y_next = '0;
                ax1_next    = OP_W'(point_x);
                bx1_next    = scale_x;
                ay1_next    = OP_W'(point_y);
                by1_next    = scale_y;
            end
            CMD_REFLECT_Y:
            begin
                base_y_next = (BASE_W'(pivot_y) <<< 1) - BASE_W'(point_y);
            end
            CMD_REFLECT_X:
            begin
                base_x_next = (BASE_W'(pivot_x) <<< 1) - BASE_W'(point_x);
            end
            CMD_REFLECT_XY:
            begin
                base_x_next = (BASE_W'(pivot_x) <<< 1) - BASE_W'(point_x);
                base_y_next = (BASE_W'(pivot_y) <<< 1) - BASE_W'(point_y);
            end
            CMD_SHEAR_X:
            begin
                ax1_next = OP_W'(point_y);
                bx1_next = shear_factor;
            end
            CMD_SHEAR_Y:
            begin
                ay1_next = OP_W'(point_x);
                by1_next = shear_factor;
            end
            default: ;
        endcase
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg.valid <= accept;
            ctrl_reg.rot   <= rot_next;
        end
    end

    // operand register
    always_ff @(posedge clk)
    begin
        if (accept) begin
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
            ax1_reg    <= ax1_next;
            ax2_reg    <= ax2_next;
            ay1_reg    <= ay1_next;
            ay2_reg    <= ay2_next;
            bx1_reg    <= bx1_next;
            bx2_reg    <= bx2_next;
            by1_reg    <= by1_next;
            by2_reg    <= by2_next;
        end
    end

    assign ctrl   = ctrl_reg;
    assign base_x = base_x_reg;
    assign base_y = base_y_reg;
    assign ax1    = ax1_reg;
    assign ax2    = ax2_reg;
    assign ay1    = ay1_reg;
    assign ay2    = ay2_reg;
    assign bx1    = bx1_reg;
    assign bx2    = bx2_reg;
    assign by1    = by1_reg;
    assign by2    = by2_reg;

endmodule

// ===== sv/pt2d_mul.sv =====
module pt2d_mul
    import pt2d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  stage_ctrl_t                                ctrl_in,
    input  logic signed [COORD_BITS+1:0]               base_x_in,
    input  logic signed [COORD_BITS+1:0]               base_y_in,
    input  logic signed [COORD_BITS:0]                 ax1,
    input  logic signed [COORD_BITS:0]                 ax2,
    input  logic signed [COORD_BITS:0]                 ay1,
    input  logic signed [COORD_BITS:0]                 ay2,
    input  logic signed [FACTOR_BITS-1:0]              bx1,
    input  logic signed [FACTOR_BITS-1:0]              bx2,
    input  logic signed [FACTOR_BITS-1:0]              by1,
    input  logic signed [FACTOR_BITS-1:0]              by2,
    output stage_ctrl_t                                ctrl_out,
    output logic signed [COORD_BITS+1:0]               base_x_out,
    output logic signed [COORD_BITS+1:0]               base_y_out,
    output logic signed [COORD_BITS+30-FRAC_BITS:0]    px1,
    output logic signed [COORD_BITS+30-FRAC_BITS:0]    px2,
    output logic signed [COORD_BITS+30-FRAC_BITS:0]    py1,
    output logic signed [COORD_BITS+30-FRAC_BITS:0]    py2
);

    localparam int PROD_W = COORD_BITS + 1 + FACTOR_BITS;
    localparam int ACC_W  = COORD_BITS + 31 - FRAC_BITS;
    localparam int ALIGN  = TRIG_FRAC - FRAC_BITS;

    stage_ctrl_t                ctrl_reg;
    logic signed [COORD_BITS+1:0] base_x_reg, base_y_reg;
    logic signed [PROD_W-1:0]   mx1, mx2, my1, my2;
    logic signed [ACC_W-1:0]    px1_reg, px2_reg, py1_reg, py2_reg;
    logic signed [ACC_W-1:0]    px1_next, px2_next, py1_next, py2_next;

    // four products, then aligned to the rotation fraction point
    always_comb
    begin
        mx1 = PROD_W'(ax1) * PROD_W'(bx1);
        mx2 = PROD_W'(ax2) * PROD_W'(bx2);
        my1 = PROD_W'(ay1) * PROD_W'(by1);
        my2 = PROD_W'(ay2) * PROD_W'(by2);
        if (ctrl_in.rot) begin
            px1_next = ACC_W'(mx1);
            px2_next = ACC_W'(mx2);
            py1_next = ACC_W'(my1);
            py2_next = ACC_W'(my2);
        end else begin
            px1_next = ACC_W'(mx1) <<< ALIGN;
            px2_next = ACC_W'(mx2) <<< ALIGN;
            py1_next = ACC_W'(my1) <<< ALIGN;
            py2_next = ACC_W'(my2) <<< ALIGN;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_in;
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (ctrl_in.valid) begin
            base_x_reg <= base_x_in;
            base_y_reg <= base_y_in;
            px1_reg    <= px1_next;
            px2_reg    <= px2_next;
            py1_reg    <= py1_next;
            py2_reg    <= py2_next;
        end
    end

    assign ctrl_out   = ctrl_reg;
    assign base_x_out = base_x_reg;
    assign base_y_out = base_y_reg;
    assign px1        = px1_reg;
    assign px2        = px2_reg;
    assign py1        = py1_reg;
    assign py2        = py2_reg;

endmodule

// ===== sv/pt2d_round.sv =====
module pt2d_round
    import pt2d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  stage_ctrl_t                                ctrl_in,
    input  logic signed [COORD_BITS+1:0]               base_x,
    input  logic signed [COORD_BITS+1:0]               base_y,
    input  logic signed [COORD_BITS+30-FRAC_BITS:0]    px1,
    input  logic signed [COORD_BITS+30-FRAC_BITS:0]    px2,
    input  logic signed [COORD_BITS+30-FRAC_BITS:0]    py1,
    input  logic signed [COORD_BITS+30-FRAC_BITS:0]    py2,
    output logic                                       done,
    output logic signed [COORD_BITS-1:0]               result_x,
    output logic signed [COORD_BITS-1:0]               result_y,
    output logic                                       overflow
);

    localparam int ACC_W = COORD_BITS + 31 - FRAC_BITS;
    localparam int RND_W = ACC_W - TRIG_FRAC;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (TRIG_FRAC - 1));
    localparam logic signed [COORD_BITS-1:0] MAX_V = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MIN_V = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                         done_reg;
    logic signed [COORD_BITS-1:0] result_x_reg, result_y_reg, result_x_next, result_y_next;
    logic                         overflow_reg, overflow_next;
    logic signed [ACC_W-1:0]      sum_x, sum_y;
    logic signed [RND_W-1:0]      rnd_x, rnd_y;
    logic [COORD_BITS:0]          sat_x, sat_y;

    // clamp to the coordinate range, overflow flag on top
    function automatic logic [COORD_BITS:0] saturate(input logic signed [RND_W-1:0] v);
        logic [RND_W-COORD_BITS:0] upper;
        logic                      ovf;
        logic [COORD_BITS-1:0]     val;
        begin
            upper = v[RND_W-1:COORD_BITS-1];
            ovf   = !((&upper) || !(|upper));
            val   = v[COORD_BITS-1:0];
            if (ovf) begin
                val = v[RND_W-1] ? MIN_V : MAX_V;
            end
            return {ovf, val};
        end
    endfunction

    // sum, round half up, saturate
    always_comb
    begin
        sum_x = (ACC_W'(base_x) <<< TRIG_FRAC) + px1 + px2 + HALF;
        sum_y = (ACC_W'(base_y) <<< TRIG_FRAC) + py1 + py2 + HALF;
        rnd_x = sum_x[ACC_W-1:TRIG_FRAC];
        rnd_y = sum_y[ACC_W-1:TRIG_FRAC];
        sat_x = saturate(rnd_x);
        sat_y = saturate(rnd_y);
        result_x_next = sat_x[COORD_BITS-1:0];
        result_y_next = sat_y[COORD_BITS-1:0];
        overflow_next = sat_x[COORD_BITS] | sat_y[COORD_BITS];
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= ctrl_in.valid;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl_in.valid) begin
            result_x_reg <= result_x_next;
            result_y_reg <= result_y_next;
            overflow_reg <= overflow_next;
        end
    end

    assign done     = done_reg;
    assign result_x = result_x_reg;
    assign result_y = result_y_reg;
    assign overflow = overflow_reg;

endmodule

// ===== sv/point_transform_2d.sv =====
// 2D point transform: one vertex per transaction through a three-stage pipe.
// Input: a transaction is taken at each rising edge with start high and busy
// low. busy is always low, so a new vertex may be given in every cycle.
// The command selects translate, rotate about the pivot, scale about the
// origin, reflect through the pivot lines, or shear in x or y.
// Output: done is high for one cycle with result_x, result_y and overflow;
// the receiver cannot hold results off, and none is needed since each
// transaction yields exactly one result in a fixed slot.
// Stages: operand decode, multiply, then round and saturate, each registered;
// done and the result leave the last register together.
// Throughput: one vertex per cycle, set by four parallel multipliers that
// are each used once per vertex.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
// an angle write also loads sine and cosine from the quarter-wave table.
// Write registers only while no vertex is in the pipe.
// Reset: asynchronous, active low; the pipe empties, shifts, shear, pivot and
// angle go to zero and both scale factors to 1.0.
module point_transform_2d
    import pt2d_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic [CMD_BITS-1:0]                        command,
    input  logic signed [COORD_BITS-1:0]               point_x,
    input  logic signed [COORD_BITS-1:0]               point_y,
    output logic                                       done,
    output logic signed [COORD_BITS-1:0]               result_x,
    output logic signed [COORD_BITS-1:0]               result_y,
    output logic                                       overflow,
    input  logic                                       cfg_we,
    input  logic [REG_IDX_BITS-1:0]                    cfg_index,
    input  logic [((COORD_BITS > FACTOR_BITS) ? COORD_BITS : FACTOR_BITS)-1:0] cfg_wdata
);

    localparam int CFG_W = (COORD_BITS > FACTOR_BITS) ? COORD_BITS : FACTOR_BITS;
    localparam int ACC_W = COORD_BITS + 31 - FRAC_BITS;

    logic signed [COORD_BITS-1:0]  shift_x, shift_y, pivot_x, pivot_y;
    logic signed [FACTOR_BITS-1:0] scale_x, scale_y, shear_factor;
    logic signed [FACTOR_BITS-1:0] sin_val, cos_val, nsin_val;

    stage_ctrl_t                   ctrl_op, ctrl_mul;
    logic signed [COORD_BITS+1:0]  op_base_x, op_base_y, mul_base_x, mul_base_y;
    logic signed [COORD_BITS:0]    ax1, ax2, ay1, ay2;
    logic signed [FACTOR_BITS-1:0] bx1, bx2, by1, by2;
    logic signed [ACC_W-1:0]       px1, px2, py1, py2;
    logic                          accept;

    // every start is taken, the pipe never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // configuration registers
    pt2d_cfg #(
        .COORD_BITS (COORD_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .scale_x      (scale_x),
        .scale_y      (scale_y),
        .shear_factor (shear_factor),
        .sin_val      (sin_val),
        .cos_val      (cos_val),
        .nsin_val     (nsin_val),
        .pivot_x      (pivot_x),
        .pivot_y      (pivot_y)
    );

    // operand decode stage
    pt2d_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .point_x      (point_x),
        .point_y      (point_y),
        .shift_x      (shift_x),
        .shift_y      (shift_y),
        .scale_x      (scale_x),
        .scale_y      (scale_y),
        .shear_factor (shear_factor),
        .sin_val      (sin_val),
        .cos_val      (cos_val),
        .nsin_val     (nsin_val),
        .pivot_x      (pivot_x),
        .pivot_y      (pivot_y),
        .ctrl         (ctrl_op),
        .base_x       (op_base_x),
        .base_y       (op_base_y),
        .ax1          (ax1),
        .ax2          (ax2),
        .ay1          (ay1),
        .ay2          (ay2),
        .bx1          (bx1),
        .bx2          (bx2),
        .by1          (by1),
        .by2          (by2)
    );

    // multiply stage
    pt2d_mul #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (ctrl_op),
        .base_x_in  (op_base_x),
        .base_y_in  (op_base_y),
        .ax1        (ax1),
        .ax2        (ax2),
        .ay1        (ay1),
        .ay2        (ay2),
        .bx1        (bx1),
        .bx2        (bx2),
        .by1        (by1),
        .by2        (by2),
        .ctrl_out   (ctrl_mul),
        .base_x_out (mul_base_x),
        .base_y_out (mul_base_y),
        .px1        (px1),
        .px2        (px2),
        .py1        (py1),
        .py2        (py2)
    );

    // round and saturate stage
    pt2d_round #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_mul),
        .base_x   (mul_base_x),
        .base_y   (mul_base_y),
        .px1      (px1),
        .px2      (px2),
        .py1      (py1),
        .py2      (py2),
        .done     (done),
        .result_x (result_x),
        .result_y (result_y),
        .overflow (overflow)
    );

endmodule

// ===== sim/tb.sv =====
module tb;
    import pt2d_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int FW          = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 1550;

    // kinds of rows in the directed script
    localparam bit ROW_POINT = 1'b0;
    localparam bit ROW_WRITE = 1'b1;

    // sin(0..90 deg) in Q1.14
    localparam int SINE_Q14 [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 ovf;
    } vertex_t;

    // one row: a vertex transaction or a register write
    typedef struct packed {
        bit                  kind;
        logic [2:0]          code;
        logic [15:0]         a;
        logic [15:0]         b;
        bit                  typed;
        logic [15:0]         ex;
        logic [15:0]         ey;
        logic                eo;
    } step_t;

    localparam int SCRIPT_LEN = 33;
    localparam step_t SCRIPT [0:SCRIPT_LEN-1] = '{
        // reset settings: identity for everything but the reflections
        '{ROW_POINT, CMD_TRANSLATE,  16'sd0,      16'sd0,      1'b1, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_TRANSLATE,  16'sd32767,  16'sh8000,   1'b1, 16'sd32767,  16'sh8000,   1'b0},
        '{ROW_POINT, CMD_ROTATE,     16'sd32767,  16'sh8000,   1'b1, 16'sd32767,  16'sh8000,   1'b0},
        '{ROW_POINT, CMD_SCALE,      16'sh8000,   16'sd32767,  1'b1, 16'sh8000,   16'sd32767,  1'b0},
        '{ROW_POINT, CMD_REFLECT_Y,  16'sd5,      16'sh8000,   1'b1, 16'sd5,      16'sd32767,  1'b1},
        '{ROW_POINT, CMD_REFLECT_X,  16'sh8000,   16'sd7,      1'b1, 16'sd32767,  16'sd7,      1'b1},
        '{ROW_POINT, CMD_REFLECT_XY, 16'sd100,    -16'sd200,   1'b1, -16'sd100,   16'sd200,    1'b0},
        '{ROW_POINT, CMD_SHEAR_X,    16'sd1234,   -16'sd4321,  1'b1, 16'sd1234,   -16'sd4321,  1'b0},
        '{ROW_POINT, CMD_SHEAR_Y,    -16'sd1,     16'sd1,      1'b1, -16'sd1,     16'sd1,      1'b0},
        // extreme shifts saturate both ways
        '{ROW_WRITE, REG_SHIFT_X,    16'sd32767,  16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_WRITE, REG_SHIFT_Y,    16'sh8000,   16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_TRANSLATE,  16'sd1,      -16'sd1,     1'b1, 16'sd32767,  16'sh8000,   1'b1},
        '{ROW_POINT, CMD_TRANSLATE,  16'sh8000,   16'sd32767,  1'b1, -16'sd1,     -16'sd1,     1'b0},
        // scale -128.0 and 0.5: half-way cases round up
        '{ROW_WRITE, REG_SCALE_X,    16'sh8000,   16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_WRITE, REG_SCALE_Y,    16'sd128,    16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_SCALE,      16'sd1,      16'sd1,      1'b1, -16'sd128,   16'sd1,      1'b0},
        '{ROW_POINT, CMD_SCALE,      -16'sd1,     -16'sd1,     1'b1, 16'sd128,    16'sd0,      1'b0},
        '{ROW_POINT, CMD_SCALE,      16'sd32767,  16'sd3,      1'b1, 16'sh8000,   16'sd2,      1'b1},
        // quarter turn, then the same angle written out of range
        '{ROW_WRITE, REG_ANGLE,      16'd90,      16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_ROTATE,     16'sd10,     16'sd0,      1'b1, 16'sd0,      16'sd10,     1'b0},
        '{ROW_WRITE, REG_ANGLE,      16'd450,     16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_ROTATE,     16'sd0,      16'sd10,     1'b1, -16'sd10,    16'sd0,      1'b0},
        '{ROW_WRITE, REG_ANGLE,      16'hffff,    16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_ROTATE,     16'sh8000,   16'sh8000,   1'b0, 16'sd0,      16'sd0,      1'b0},
        // pivot at the far corner
        '{ROW_WRITE, REG_PIVOT_X,    16'sd32767,  16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_WRITE, REG_PIVOT_Y,    16'sh8000,   16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_REFLECT_XY, 16'sh8000,   16'sd32767,  1'b1, 16'sd32767,  16'sh8000,   1'b1},
        '{ROW_POINT, CMD_ROTATE,     16'sd0,      16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_ROTATE,     16'sd32767,  16'sh8000,   1'b1, 16'sd32767,  16'sh8000,   1'b0},
        // extreme shear factors
        '{ROW_WRITE, REG_SHEAR,      16'sd32767,  16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_SHEAR_X,    16'sd0,      16'sh8000,   1'b1, 16'sh8000,   16'sh8000,   1'b1},
        '{ROW_WRITE, REG_SHEAR,      16'sh8000,   16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0},
        '{ROW_POINT, CMD_SHEAR_Y,    16'sd1,      16'sd0,      1'b0, 16'sd0,      16'sd0,      1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        command;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic              done;
    logic signed [CW-1:0] result_x;
    logic signed [CW-1:0] result_y;
    logic              overflow;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [15:0]       cfg_wdata;

    // register shadow
    logic signed [CW-1:0] shift_x_q;
    logic signed [CW-1:0] shift_y_q;
    logic signed [15:0]   scale_x_q;
    logic signed [15:0]   scale_y_q;
    logic signed [15:0]   shear_q;
    logic [8:0]           angle_q;
    logic signed [CW-1:0] pivot_x_q;
    logic signed [CW-1:0] pivot_y_q;

    vertex_t expected_vertices [$];
    int      errors;
    bit      gaps_on;

    point_transform_2d DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .point_x   (point_x),
        .point_y   (point_y),
        .done      (done),
        .result_x  (result_x),
        .result_y  (result_y),
        .overflow  (overflow),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // signed sine of 0..359 degrees in Q1.14
    function automatic longint sin_q14(input int deg);
        int     quad;
        int     rem;
        longint s;
        quad = deg / 90;
        rem  = deg % 90;
        s = (quad == 0 || quad == 2) ? SINE_Q14[rem] : SINE_Q14[90 - rem];
        return (quad >= 2) ? -s : s;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic longint round_shift(input longint v, input int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[CW-1:0];
    endfunction

    // expected vertex under the current register settings
    function automatic vertex_t transform_vertex(input logic [2:0] cmd,
                                                 input logic signed [CW-1:0] in_x,
                                                 input logic signed [CW-1:0] in_y);
        longint  x, y, rx, ry, px, py, dx, dy, s, c, f;
        int      ang;
        vertex_t r;
        x  = in_x;
        y  = in_y;
        px = pivot_x_q;
        py = pivot_y_q;
        f  = shear_q;
        rx = x;
        ry = y;
        case (cmd)
            CMD_TRANSLATE:
            begin
                rx = x + longint'(shift_x_q);
                ry = y + longint'(shift_y_q);
            end
            CMD_ROTATE:
            begin
                ang = int'(angle_q) % 360;
                s   = sin_q14(ang);
                c   = sin_q14((ang + 90) % 360);
                dx  = x - px;
                dy  = y - py;
                rx  = round_shift((px <<< TRIG_FRAC) + dx * c - dy * s, TRIG_FRAC);
                ry  = round_shift((py <<< TRIG_FRAC) + dx * s + dy * c, TRIG_FRAC);
            end
            CMD_SCALE:
            begin
                rx = round_shift(x * longint'(scale_x_q), FW);
                ry = round_shift(y * longint'(scale_y_q), FW);
            end
            CMD_REFLECT_Y:  ry = 2 * py - y;
            CMD_REFLECT_X:  rx = 2 * px - x;
            CMD_REFLECT_XY:
            begin
                rx = 2 * px - x;
                ry = 2 * py - y;
            end
            CMD_SHEAR_X:    rx = round_shift((x <<< FW) + y * f, FW);
            default:        ry = round_shift((y <<< FW) + x * f, FW);
        endcase
        r.x   = clamp_coord(rx);
        r.y   = clamp_coord(ry);
        r.ovf = (longint'(r.x) != rx) || (longint'(r.y) != ry);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // stop sending and wait until every transaction has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_vertices.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_we high; the next vertex transaction lowers it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_SHIFT_X: shift_x_q = val;
            REG_SHIFT_Y: shift_y_q = val;
            REG_SCALE_X: scale_x_q = val;
            REG_SCALE_Y: scale_y_q = val;
            REG_SHEAR:   shear_q   = val;
            REG_ANGLE:   angle_q   = val[8:0];
            REG_PIVOT_X: pivot_x_q = val;
            default:     pivot_y_q = val;
        endcase
    endtask

    task automatic send_vertex(input logic [2:0] cmd, input logic signed [CW-1:0] x,
                               input logic signed [CW-1:0] y, input bit typed,
                               input vertex_t want);
        cfg_we <= 1'b0;
        while (gaps_on && $urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        point_x <= x;
        point_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_vertices.push_back(typed ? want : transform_vertex(cmd, x, y));
    endtask

    // extremes often, otherwise modest or full-range values
    function automatic logic [15:0] pick_word(input bit modest);
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return modest ? 16'($urandom_range(0, 1023) - 512) : 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] reg_value(input int idx);
        case (idx)
            REG_SCALE_X, REG_SCALE_Y:
                return ($urandom_range(0, 3) == 0) ? 16'(FACTOR_ONE) : pick_word(1'b1);
            REG_ANGLE:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'($urandom_range(360, 511));
                    1:       return 16'($urandom);
                    default: return 16'($urandom_range(0, 359));
                endcase
            end
            default:
                return pick_word($urandom_range(0, 2) != 0);
        endcase
    endfunction

    // compare each result with the oldest expectation
    always @(posedge clk) begin
        vertex_t want;
        if (rst_n && done) begin
            if (expected_vertices.size() == 0) begin
                report_mismatch("unexpected result_x", result_x, 0);
            end else begin
                want = expected_vertices.pop_front();
                if (result_x !== want.x)
                    report_mismatch("result_x", result_x, want.x);
                if (result_y !== want.y)
                    report_mismatch("result_y", result_y, want.y);
                if (overflow !== want.ovf)
                    report_mismatch("overflow", overflow, want.ovf);
            end
        end
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        vertex_t want;
        int      sent;
        int      n;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_TRANSLATE;
        point_x   = '0;
        point_y   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_SHIFT_X;
        cfg_wdata = '0;
        errors    = 0;
        gaps_on   = 1'b1;
        shift_x_q = '0;
        shift_y_q = '0;
        scale_x_q = FACTOR_ONE;
        scale_y_q = FACTOR_ONE;
        shear_q   = '0;
        angle_q   = '0;
        pivot_x_q = '0;
        pivot_y_q = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].kind == ROW_WRITE) begin
                settle();
                write_reg(SCRIPT[i].code, SCRIPT[i].a);
            end else begin
                want.x   = SCRIPT[i].ex;
                want.y   = SCRIPT[i].ey;
                want.ovf = SCRIPT[i].eo;
                send_vertex(SCRIPT[i].code, SCRIPT[i].a, SCRIPT[i].b, SCRIPT[i].typed, want);
            end
        end

        // random phases; a phase with gaps first rewrites a random set of registers
        sent = 0;
        want = '0;
        while (sent < RANDOM_ITEMS) begin
            // a long stretch runs back to back under one register setting
            gaps_on = !(sent >= 600 && sent < 1000);
            if (gaps_on) begin
                settle();
                for (int r = REG_SHIFT_X; r <= REG_PIVOT_Y; r++)
                    if ($urandom_range(0, 1) == 1)
                        write_reg(3'(r), reg_value(r));
            end
            n = $urandom_range(20, 80);
            for (int i = 0; i < n; i++)
                send_vertex(3'($urandom_range(0, 7)), pick_word($urandom_range(0, 1) == 1),
                            pick_word($urandom_range(0, 1) == 1), 1'b0, want);
            sent += n;
        end

        settle();
        repeat (5) @(posedge clk);
        if (expected_vertices.size() != 0)
            report_mismatch("results missing", 0, expected_vertices.size());
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== point_transform_2d.f =====
sv/pt2d_pkg.sv
sv/pt2d_cfg.sv
sv/pt2d_prep.sv
sv/pt2d_mul.sv
sv/pt2d_round.sv
sv/point_transform_2d.sv
sim/tb.sv
